### rtl/vtp_pkg.sv
// Shared types, codes and reset values for the vertex transform and projection block.
`default_nettype none
package vtp_pkg;

    // Point operation codes; codes 5 to 7 behave as the affine transform
    typedef enum logic [2:0] {
        MODE_AFFINE       = 3'd0,
        MODE_AFFINE_PROJ  = 3'd1,
        MODE_ROTATE       = 3'd2,
        MODE_PRETRANSLATE = 3'd3,
        MODE_PROJECT      = 3'd4
    } t_mode;

    // Configuration register indexes
    localparam logic [2:0] REG_ROW_X  = 3'd0;
    localparam logic [2:0] REG_ROW_Y  = 3'd1;
    localparam logic [2:0] REG_ROW_Z  = 3'd2;
    localparam logic [2:0] REG_SHIFT_X = 3'd3;
    localparam logic [2:0] REG_SHIFT_Y = 3'd4;
    localparam logic [2:0] REG_SHIFT_Z = 3'd5;
    localparam logic [2:0] REG_DIST   = 3'd6;

    localparam int ROW_W   = 48;
    localparam int COEF_W  = 16;
    localparam int COORD_W = 32;
    localparam int DIST_W  = 31;
    localparam int NUM_W   = 62;   // magnitude of coordinate times distance
    localparam int DEN_W   = 33;   // magnitude of distance plus z
    localparam int QUO_W   = 32;   // quotient bits produced by the divider

    localparam logic [ROW_W-1:0]  ROW_X_RST = 48'h0000_0000_1000;
    localparam logic [ROW_W-1:0]  ROW_Y_RST = 48'h0000_1000_0000;
    localparam logic [ROW_W-1:0]  ROW_Z_RST = 48'h1000_0000_0000;
    localparam logic [DIST_W-1:0] DIST_RST  = 31'h0100_0000;

    localparam logic signed [COORD_W-1:0] SAT_HI = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] SAT_LO = 32'sh8000_0000;

    // Per-beat side information carried alongside the divider
    typedef struct packed {
        logic                      last;
        logic                      ovf;
        logic                      proj;
        logic                      fault;
        logic                      neg_x;
        logic                      neg_y;
        logic                      big_x;
        logic                      big_y;
        logic signed [COORD_W-1:0] ox;
        logic signed [COORD_W-1:0] oy;
        logic signed [COORD_W-1:0] oz;
    } t_side;

endpackage
`default_nettype wire

### rtl/vtp_div.sv
// Pipelined restoring divider of a magnitude, one quotient bit per stage.
`default_nettype none
module vtp_div (
    input  wire logic                           i_clk,
    input  wire logic                           i_en,
    input  wire logic [vtp_pkg::NUM_W-1:0]      i_num,
    input  wire logic [vtp_pkg::DEN_W-1:0]      i_den,
    output logic      [vtp_pkg::QUO_W-1:0]      o_quo
);
    localparam int QW = vtp_pkg::QUO_W;
    localparam int NW = vtp_pkg::NUM_W;
    localparam int DW = vtp_pkg::DEN_W;
    localparam int SW = DW + QW;

    logic [NW-1:0] rem_in [0:QW-1];
    logic [DW-1:0] den_in [0:QW-1];
    logic [QW-1:0] quo_in [0:QW-1];

    logic [NW-1:0] r_rem [0:QW-1];
    logic [DW-1:0] r_den [0:QW-1];
    logic [QW-1:0] r_quo [0:QW-1];

    assign rem_in[0] = i_num;
    assign den_in[0] = i_den;
    assign quo_in[0] = '0;

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [SW:0]   diff;
        logic [QW-1:0] n_quo;

        // trial subtract of the divisor aligned to this quotient bit
        assign diff = {{(SW + 1 - NW){1'b0}}, rem_in[k]}
                    - ({{(QW + 1){1'b0}}, den_in[k]} << (QW - 1 - k));

        always_comb begin
            n_quo = quo_in[k];
            n_quo[QW-1-k] = ~diff[SW];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= diff[SW] ? rem_in[k] : diff[NW-1:0];
                r_den[k] <= den_in[k];
                r_quo[k] <= n_quo;
            end
        end

        if (k < QW - 1) begin : g_link
            assign rem_in[k+1] = r_rem[k];
            assign den_in[k+1] = r_den[k];
            assign quo_in[k+1] = r_quo[k];
        end
    end

    assign o_quo = r_quo[QW-1];

endmodule
`default_nettype wire

### rtl/vertex_transform_project.sv
// Top level: matrix transform, translation and perspective divide pipeline.
`default_nettype none
// Transforms one signed Q16.16 point per cycle: a Q4.12 3x3 matrix (modes 0
// to 3) plus translation after it (modes 0 and 1) or before it (mode 3),
// optionally followed by scaling x and y by d/(d+z) (modes 1 and 4). Each
// input beat passes through one input stage, one multiply stage, one sum/round
// stage, one distance multiply stage, one magnitude stage, 32 divider stages
// (one quotient bit each) and the output register. A new beat is taken every
// cycle; the whole pipeline holds while a result beat is stalled.
// Configuration must be written only while the pipeline is empty.
module vertex_transform_project (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [47:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [2:0]  i_mode,
    input  wire logic signed [31:0] i_in_x,
    input  wire logic signed [31:0] i_in_y,
    input  wire logic signed [31:0] i_in_z,
    input  wire logic        i_last_point,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic signed [31:0] o_out_z,
    output logic             o_last_out,
    output logic             o_overflow,
    output logic             o_divide_fault
);
    localparam int CW = vtp_pkg::COORD_W;
    localparam int QW = vtp_pkg::QUO_W;

    // configuration registers
    logic [47:0]        r_row [0:2];
    logic signed [31:0] r_shift [0:2];
    logic [30:0]        r_dist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row[0]   <= vtp_pkg::ROW_X_RST;
            r_row[1]   <= vtp_pkg::ROW_Y_RST;
            r_row[2]   <= vtp_pkg::ROW_Z_RST;
            r_shift[0] <= '0;
            r_shift[1] <= '0;
            r_shift[2] <= '0;
            r_dist     <= vtp_pkg::DIST_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                vtp_pkg::REG_ROW_X:   r_row[0]   <= i_cfg_data;
                vtp_pkg::REG_ROW_Y:   r_row[1]   <= i_cfg_data;
                vtp_pkg::REG_ROW_Z:   r_row[2]   <= i_cfg_data;
                vtp_pkg::REG_SHIFT_X: r_shift[0] <= i_cfg_data[31:0];
                vtp_pkg::REG_SHIFT_Y: r_shift[1] <= i_cfg_data[31:0];
                vtp_pkg::REG_SHIFT_Z: r_shift[2] <= i_cfg_data[31:0];
                vtp_pkg::REG_DIST:    r_dist     <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // global advance: hold everything while the result beat is stalled
    logic en;
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    // ---------------- stage 1: decode mode, pretranslate ----------------
    logic               r_s1_vld;
    logic signed [32:0] r_s1_p [0:2];
    logic signed [31:0] r_s1_t [0:2];
    logic               r_s1_bypass, r_s1_proj, r_s1_last;

    logic signed [31:0] in_c [0:2];
    assign in_c[0] = i_in_x;
    assign in_c[1] = i_in_y;
    assign in_c[2] = i_in_z;

    logic m_pre, m_rot, m_byp, m_proj;
    always_comb begin
        m_pre  = (i_mode == vtp_pkg::MODE_PRETRANSLATE);
        m_rot  = (i_mode == vtp_pkg::MODE_ROTATE);
        m_byp  = (i_mode == vtp_pkg::MODE_PROJECT);
        m_proj = m_byp || (i_mode == vtp_pkg::MODE_AFFINE_PROJ);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s1_vld <= 1'b0;
        else if (en)  r_s1_vld <= i_valid;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                r_s1_p[c] <= m_pre ? 33'(in_c[c]) + 33'(r_shift[c]) : 33'(in_c[c]);
                r_s1_t[c] <= (m_pre || m_rot || m_byp) ? 32'sd0 : r_shift[c];
            end
            r_s1_bypass <= m_byp;
            r_s1_proj   <= m_proj;
            r_s1_last   <= i_last_point;
        end
    end

    // ---------------- stage 2: nine coefficient products ----------------
    logic               r_s2_vld;
    logic signed [48:0] r_s2_prod [0:2][0:2];
    logic signed [31:0] r_s2_t [0:2];
    logic signed [31:0] r_s2_raw [0:2];
    logic               r_s2_bypass, r_s2_proj, r_s2_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s2_vld <= 1'b0;
        else if (en)  r_s2_vld <= r_s1_vld;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_s2_prod[r][c] <= 49'($signed(r_row[r][16*c +: 16]))
                                     * 49'(r_s1_p[c]);
                end
                r_s2_t[r]   <= r_s1_t[r];
                r_s2_raw[r] <= r_s1_p[r][31:0];
            end
            r_s2_bypass <= r_s1_bypass;
            r_s2_proj   <= r_s1_proj;
            r_s2_last   <= r_s1_last;
        end
    end

    // ---------------- stage 3: sum, round half up, saturate ----------------
    logic               r_s3_vld;
    logic signed [31:0] r_s3_o [0:2];
    logic               r_s3_ovf, r_s3_proj, r_s3_last;

    logic signed [51:0] acc [0:2];
    logic signed [39:0] rnd [0:2];
    logic signed [31:0] n_s3_o [0:2];
    logic               n_s3_ovf;

    always_comb begin
        n_s3_ovf = 1'b0;
        for (int r = 0; r < 3; r++) begin
            acc[r] = 52'(r_s2_prod[r][0]) + 52'(r_s2_prod[r][1]) + 52'(r_s2_prod[r][2])
                   + (52'(r_s2_t[r]) <<< 12) + 52'sd2048;
            rnd[r] = acc[r][51:12];
            if (r_s2_bypass) begin
                n_s3_o[r] = r_s2_raw[r];
            end else if (rnd[r] > 40'(vtp_pkg::SAT_HI)) begin
                n_s3_o[r] = vtp_pkg::SAT_HI;
                n_s3_ovf  = 1'b1;
            end else if (rnd[r] < 40'(vtp_pkg::SAT_LO)) begin
                n_s3_o[r] = vtp_pkg::SAT_LO;
                n_s3_ovf  = 1'b1;
            end else begin
                n_s3_o[r] = rnd[r][31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s3_vld <= 1'b0;
        else if (en)  r_s3_vld <= r_s2_vld;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int r = 0; r < 3; r++) r_s3_o[r] <= n_s3_o[r];
            r_s3_ovf  <= n_s3_ovf;
            r_s3_proj <= r_s2_proj;
            r_s3_last <= r_s2_last;
        end
    end

    // ---------------- stage 4: numerators and denominator ----------------
    logic               r_s4_vld;
    logic signed [63:0] r_s4_num_x, r_s4_num_y;
    logic signed [32:0] r_s4_den;
    logic signed [31:0] r_s4_o [0:2];
    logic               r_s4_ovf, r_s4_proj, r_s4_last;

    logic signed [31:0] dist_s;
    assign dist_s = $signed({1'b0, r_dist});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s4_vld <= 1'b0;
        else if (en)  r_s4_vld <= r_s3_vld;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s4_num_x <= 64'(r_s3_o[0]) * 64'(dist_s);
            r_s4_num_y <= 64'(r_s3_o[1]) * 64'(dist_s);
            r_s4_den   <= 33'(r_s3_o[2]) + 33'(dist_s);
            for (int r = 0; r < 3; r++) r_s4_o[r] <= r_s3_o[r];
            r_s4_ovf  <= r_s3_ovf;
            r_s4_proj <= r_s3_proj;
            r_s4_last <= r_s3_last;
        end
    end

    // ---------------- stage 5: magnitudes, range and zero checks ----------------
    logic        r_s5_vld;
    logic [61:0] r_s5_mag_x, r_s5_mag_y;
    logic [32:0] r_s5_mag_d;
    vtp_pkg::t_side r_s5_side;

    logic [63:0] abs_x, abs_y;
    logic [32:0] abs_d;
    vtp_pkg::t_side n_s5_side;

    always_comb begin
        abs_x = r_s4_num_x[63] ? 64'(-r_s4_num_x) : 64'(r_s4_num_x);
        abs_y = r_s4_num_y[63] ? 64'(-r_s4_num_y) : 64'(r_s4_num_y);
        abs_d = r_s4_den[32] ? 33'(-r_s4_den) : 33'(r_s4_den);
        n_s5_side.last  = r_s4_last;
        n_s5_side.ovf   = r_s4_ovf;
        n_s5_side.proj  = r_s4_proj;
        n_s5_side.fault = r_s4_proj && (r_s4_den == 33'sd0);
        n_s5_side.neg_x = r_s4_num_x[63] ^ r_s4_den[32];
        n_s5_side.neg_y = r_s4_num_y[63] ^ r_s4_den[32];
        // quotient needs more than 32 bits
        n_s5_side.big_x = {1'b0, abs_x} >= {abs_d, 32'd0};
        n_s5_side.big_y = {1'b0, abs_y} >= {abs_d, 32'd0};
        n_s5_side.ox    = r_s4_o[0];
        n_s5_side.oy    = r_s4_o[1];
        n_s5_side.oz    = r_s4_o[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s5_vld <= 1'b0;
        else if (en)  r_s5_vld <= r_s4_vld;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s5_mag_x <= abs_x[61:0];
            r_s5_mag_y <= abs_y[61:0];
            r_s5_mag_d <= abs_d;
            r_s5_side  <= n_s5_side;
        end
    end

    // ---------------- divider stages ----------------
    logic [QW-1:0] quo_x, quo_y;

    vtp_div u_div_x (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_s5_mag_x),
        .i_den (r_s5_mag_d),
        .o_quo (quo_x)
    );

    vtp_div u_div_y (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_s5_mag_y),
        .i_den (r_s5_mag_d),
        .o_quo (quo_y)
    );

    logic           r_dv_vld  [0:QW-1];
    vtp_pkg::t_side r_dv_side [0:QW-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < QW; k++) r_dv_vld[k] <= 1'b0;
        end else if (en) begin
            r_dv_vld[0] <= r_s5_vld;
            for (int k = 1; k < QW; k++) r_dv_vld[k] <= r_dv_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv_side[0] <= r_s5_side;
            for (int k = 1; k < QW; k++) r_dv_side[k] <= r_dv_side[k-1];
        end
    end

    // ---------------- output: sign, saturate, fault ----------------
    vtp_pkg::t_side sd;
    assign sd = r_dv_side[QW-1];

    logic signed [31:0] n_ox, n_oy;
    logic               n_ovf;

    always_comb begin
        n_ox  = sd.ox;
        n_oy  = sd.oy;
        n_ovf = sd.ovf;
        if (sd.fault) begin
            n_ox = '0;
            n_oy = '0;
        end else if (sd.proj) begin
            if (sd.neg_x) begin
                if (sd.big_x || quo_x > 32'h8000_0000) begin
                    n_ox = vtp_pkg::SAT_LO;
                    n_ovf = 1'b1;
                end else begin
                    n_ox = $signed(-quo_x);
                end
            end else if (sd.big_x || quo_x[QW-1]) begin
                n_ox = vtp_pkg::SAT_HI;
                n_ovf = 1'b1;
            end else begin
                n_ox = $signed(quo_x);
            end
            if (sd.neg_y) begin
                if (sd.big_y || quo_y > 32'h8000_0000) begin
                    n_oy = vtp_pkg::SAT_LO;
                    n_ovf = 1'b1;
                end else begin
                    n_oy = $signed(-quo_y);
                end
            end else if (sd.big_y || quo_y[QW-1]) begin
                n_oy = vtp_pkg::SAT_HI;
                n_ovf = 1'b1;
            end else begin
                n_oy = $signed(quo_y);
            end
        end
    end

    logic r_out_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_vld <= 1'b0;
        else if (en)  r_out_vld <= r_dv_vld[QW-1];
    end

    logic signed [CW-1:0] r_ox, r_oy, r_oz;
    logic                 r_last, r_ovf, r_fault;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ox    <= n_ox;
            r_oy    <= n_oy;
            r_oz    <= sd.oz;
            r_last  <= sd.last;
            r_ovf   <= n_ovf;
            r_fault <= sd.fault;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_out_x        = r_ox;
    assign o_out_y        = r_oy;
    assign o_out_z        = r_oz;
    assign o_last_out     = r_last;
    assign o_overflow     = r_ovf;
    assign o_divide_fault = r_fault;

endmodule
`default_nettype wire
